// File: sv/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types for the segment closest-point pipeline: the case flags that
// travel with each word from the dot-product front end to the edge picker.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Branch flags of the edge search, decided once in the front end
  typedef struct packed {
    logic bnd;      // answer comes from the edge search
    logic s0_zero;  // side s=0 clamps to t=0
    logic s0_full;  // side s=0 clamps to t=1
    logic s1_zero;  // side s=1 clamps to t=0
    logic s1_full;  // side s=1 clamps to t=1
    logic t0_ok;    // side t=0 has an inner candidate
    logic t1_ok;    // side t=1 has an inner candidate
  } ssc_case_t;

  localparam int SSC_CASE_BITS = $bits(ssc_case_t);

endpackage

// File: sv/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front
// Five-stage front end: edge vectors, dot products, Gram products, the
// determinant and right-hand sides, then the interior test and the divider
// operands for all four divider lanes.
// ----------------------------------------------------------------------------
module ssc_front import ssc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [COORD_BITS-1:0]  pt_i [12],
  output logic                          vld_o,
  output logic [4*COORD_BITS+8:0]       num_o [4],
  output logic [4*COORD_BITS+8:0]       den_o [4],
  output logic [9*(COORD_BITS+1)+7*(2*COORD_BITS+8)+SSC_CASE_BITS-1:0] side_o
);

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D + 2;
  localparam int Q = 2 * P + 1;
  localparam int E = P + 4;

  logic [4:0] vld_r;

  // stage 1: edge vectors
  logic signed [D-1:0] u_nxt [3], v_nxt [3], w_nxt [3];
  logic signed [D-1:0] u1_r [3], v1_r [3], w1_r [3];
  logic [9*D-1:0] cw_c, cw2_r, cw3_r, cw4_r, cw5_r;

  // stage 2: dot products
  logic signed [2*D-1:0] pr [15];
  logic signed [P-1:0] uu_nxt, vv_nxt, uv_nxt, uw_nxt, vw_nxt;
  logic signed [P-1:0] uu2_r, vv2_r, uv2_r, uw2_r, vw2_r;

  // stage 3: Gram products and derived sums
  logic signed [2*P-1:0] m_nxt [6], m3_r [6];
  logic signed [E-1:0] a_e, b_e, nvw_e, uu2uw_e, vv2vw_e, e11_e, uu_e, vv_e, uw_e, vw_e;
  logic signed [E-1:0] uu3_r, vv3_r, nvw3_r;
  logic [7*E-1:0] ev3_r, ev4_r, ev5_r;

  // stage 4: determinant, right-hand sides, edge flags
  logic signed [Q-1:0] den_nxt, rhs1_nxt, rhs2_nxt;
  logic signed [Q-1:0] den4_r, rhs14_r, rhs24_r;
  logic signed [E-1:0] uu4_r, vv4_r, nvw4_r;
  logic signed [E-1:0] ea, eb, euw, evw;
  ssc_case_t fl_nxt, fl4_r, fl5_r;

  // stage 5: divider operands
  logic [Q-1:0] num_r [4], den_r [4];
  logic bnd_c;

  // valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_nxt[k] = D'(pt_i[3+k]) - D'(pt_i[k]);
      v_nxt[k] = D'(pt_i[9+k]) - D'(pt_i[6+k]);
      w_nxt[k] = D'(pt_i[6+k]) - D'(pt_i[k]);
    end
  end

  assign cw_c = {u1_r[0], u1_r[1], u1_r[2], v1_r[0], v1_r[1], v1_r[2],
                 w1_r[0], w1_r[1], w1_r[2]};

  // form the five dot products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr[k]      = u1_r[k] * u1_r[k];
      pr[3+k]    = v1_r[k] * v1_r[k];
      pr[6+k]    = u1_r[k] * v1_r[k];
      pr[9+k]    = u1_r[k] * w1_r[k];
      pr[12+k]   = v1_r[k] * w1_r[k];
    end
    uu_nxt = P'(pr[0])  + P'(pr[1])  + P'(pr[2]);
    vv_nxt = P'(pr[3])  + P'(pr[4])  + P'(pr[5]);
    uv_nxt = P'(pr[6])  + P'(pr[7])  + P'(pr[8]);
    uw_nxt = P'(pr[9])  + P'(pr[10]) + P'(pr[11]);
    vw_nxt = P'(pr[12]) + P'(pr[13]) + P'(pr[14]);
  end

  // Gram products and the small sums used by the edge search
  always_comb begin
    m_nxt[0] = uu2_r * vv2_r;
    m_nxt[1] = uv2_r * uv2_r;
    m_nxt[2] = vv2_r * uw2_r;
    m_nxt[3] = uv2_r * vw2_r;
    m_nxt[4] = uv2_r * uw2_r;
    m_nxt[5] = uu2_r * vw2_r;
    uu_e    = E'(uu2_r);
    vv_e    = E'(vv2_r);
    uw_e    = E'(uw2_r);
    vw_e    = E'(vw2_r);
    a_e     = E'(uv2_r) - vw_e;
    b_e     = E'(uv2_r) + uw_e;
    nvw_e   = -vw_e;
    uu2uw_e = uu_e - (uw_e <<< 1);
    vv2vw_e = vv_e + (vw_e <<< 1);
    e11_e   = vv_e + ((vw_e - b_e) <<< 1) + uu_e;
  end

  // determinant, right-hand sides and edge-search flags
  always_comb begin
    evw = $signed(ev3_r[6*E +: E]);
    ea  = $signed(ev3_r[5*E +: E]);
    euw = $signed(ev3_r[4*E +: E]);
    eb  = $signed(ev3_r[3*E +: E]);
    den_nxt  = Q'(m3_r[0]) - Q'(m3_r[1]);
    rhs1_nxt = Q'(m3_r[2]) - Q'(m3_r[3]);
    rhs2_nxt = Q'(m3_r[4]) - Q'(m3_r[5]);
    fl_nxt.bnd     = 1'b0;
    fl_nxt.s0_zero = !evw[E-1];
    fl_nxt.s0_full = nvw3_r >= vv3_r;
    fl_nxt.s1_zero = ea <= 0;
    fl_nxt.s1_full = ea >= vv3_r;
    fl_nxt.t0_ok   = (euw > 0) && (euw < uu3_r);
    fl_nxt.t1_ok   = (eb > 0) && (eb < uu3_r);
  end

  assign bnd_c = !((rhs14_r > 0) && (rhs14_r < den4_r) &&
                   (rhs24_r > 0) && (rhs24_r < den4_r));

  // pipeline registers
  always_ff @(posedge clk) begin
    if (en) begin
      u1_r   <= u_nxt;
      v1_r   <= v_nxt;
      w1_r   <= w_nxt;
      cw2_r  <= cw_c;
      cw3_r  <= cw2_r;
      cw4_r  <= cw3_r;
      cw5_r  <= cw4_r;
      uu2_r  <= uu_nxt;
      vv2_r  <= vv_nxt;
      uv2_r  <= uv_nxt;
      uw2_r  <= uw_nxt;
      vw2_r  <= vw_nxt;
      m3_r   <= m_nxt;
      uu3_r  <= uu_e;
      vv3_r  <= vv_e;
      nvw3_r <= nvw_e;
      ev3_r  <= {vw_e, a_e, uw_e, b_e, vv2vw_e, uu2uw_e, e11_e};
      den4_r <= den_nxt;
      rhs14_r <= rhs1_nxt;
      rhs24_r <= rhs2_nxt;
      uu4_r  <= uu3_r;
      vv4_r  <= vv3_r;
      nvw4_r <= nvw3_r;
      ev4_r  <= ev3_r;
      fl4_r  <= fl_nxt;
      ev5_r  <= ev4_r;
      // boundary flag sits in the top bit of the case flags
      fl5_r  <= {bnd_c, fl4_r[SSC_CASE_BITS-2:0]};
      // interior lanes share the first two dividers with sides s=0 and s=1
      num_r[0] <= bnd_c ? Q'(nvw4_r) : rhs14_r;
      den_r[0] <= bnd_c ? Q'(vv4_r)  : den4_r;
      num_r[1] <= bnd_c ? Q'($signed(ev4_r[5*E +: E])) : rhs24_r;
      den_r[1] <= bnd_c ? Q'(vv4_r)  : den4_r;
      num_r[2] <= Q'($signed(ev4_r[4*E +: E]));
      den_r[2] <= Q'(uu4_r);
      num_r[3] <= Q'($signed(ev4_r[3*E +: E]));
      den_r[3] <= Q'(uu4_r);
    end
  end

  assign vld_o  = vld_r[4];
  assign num_o  = num_r;
  assign den_o  = den_r;
  assign side_o = {cw5_r, ev5_r, fl5_r};

endmodule

// File: sv/ssc_div.sv
// ----------------------------------------------------------------------------
// ssc_div
// Four-lane pipelined restoring divider: floor(n * 2^F / d) for 0 < n < d,
// two quotient bits per stage, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module ssc_div import ssc_pkg::*; #(
  parameter int W    = 73,
  parameter int F    = 16,
  parameter int SBW  = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  logic [W-1:0]   num_i [4],
  input  logic [W-1:0]   den_i [4],
  input  logic [SBW-1:0] side_i,
  output logic           vld_o,
  output logic [F-1:0]   q_o [4],
  output logic [SBW-1:0] side_o
);

  localparam int NST = (F + 1) / 2;

  logic [W:0]     rem_r [NST][4];
  logic [W-1:0]   dv_r  [NST][4];
  logic [F-1:0]   qt_r  [NST][4];
  logic [SBW-1:0] sd_r  [NST];
  logic [NST-1:0] vl_r;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [W:0]   rem_in [4], rem_nxt [4];
    logic [W-1:0] dv_in [4];
    logic [F-1:0] q_in [4], q_nxt [4];

    // pick the stage input: ports for the first stage, previous stage else
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (s == 0) begin
          rem_in[l] = {1'b0, num_i[l]};
          dv_in[l]  = den_i[l];
          q_in[l]   = '0;
        end else begin
          rem_in[l] = rem_r[(s == 0) ? 0 : s-1][l];
          dv_in[l]  = dv_r[(s == 0) ? 0 : s-1][l];
          q_in[l]   = qt_r[(s == 0) ? 0 : s-1][l];
        end
      end
    end

    // shift, trial subtract, set quotient bit
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        rem_nxt[l] = rem_in[l];
        q_nxt[l]   = q_in[l];
        for (int k = 0; k < 2; k++) begin
          if (2 * s + k < F) begin
            rem_nxt[l] = rem_nxt[l] << 1;
            q_nxt[l]   = q_nxt[l] << 1;
            if (rem_nxt[l] >= {1'b0, dv_in[l]}) begin
              rem_nxt[l] = rem_nxt[l] - {1'b0, dv_in[l]};
              q_nxt[l][0] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        dv_r[s]  <= dv_in;
        qt_r[s]  <= q_nxt;
        sd_r[s]  <= (s == 0) ? side_i : sd_r[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[s] <= 1'b0;
      end else if (en) begin
        vl_r[s] <= (s == 0) ? vld_i : vl_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign vld_o  = vl_r[NST-1];
  assign q_o    = qt_r[NST-1];
  assign side_o = sd_r[NST-1];

endmodule

// File: sv/ssc_pick.sv
// ----------------------------------------------------------------------------
// ssc_pick
// Edge search back end: candidate distances from the quotients, a two-level
// minimum that keeps the earlier candidate on a tie, and the final weights.
// ----------------------------------------------------------------------------
module ssc_pick import ssc_pkg::*; #(
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            vld_i,
  input  logic [WEIGHT_FRAC_BITS-1:0]     q_i [4],
  input  logic [9*(COORD_BITS+1)+7*(2*COORD_BITS+8)+SSC_CASE_BITS-1:0] side_i,
  output logic                            vld_o,
  output logic [WEIGHT_FRAC_BITS:0]       ws_o,
  output logic [WEIGHT_FRAC_BITS:0]       wt_o,
  output logic                            bnd_o,
  output logic [9*(COORD_BITS+1)-1:0]     cw_o
);

  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int D   = COORD_BITS + 1;
  localparam int E   = 2 * D + 6;
  localparam int R   = E + F + 2;
  localparam int CWW = 9 * D;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic [3:0] vld_r;

  // unpack the sideband word
  logic [CWW-1:0] cw_in;
  logic signed [E-1:0] vw_i, a_i, uw_i, b_i;
  ssc_case_t fl_in;

  // stage 1: products of quotients with the edge numerators
  logic signed [R-1:0] pr1_r [4];
  logic signed [R-1:0] vv2vw1_r, uu2uw1_r, e111_r;
  logic [F-1:0] q1_r [4];
  ssc_case_t fl1_r;
  logic [CWW-1:0] cw1_r;

  // stage 2: candidate distances and weights
  logic signed [R-1:0] d_nxt [4], d2_r [4];
  logic [F:0] cs_nxt [4], ct_nxt [4], cs2_r [4], ct2_r [4];
  logic [F:0] qi2_r [2];
  ssc_case_t fl2_r;
  logic [CWW-1:0] cw2_r;

  // stage 3: pairwise minimum
  logic signed [R-1:0] d01_r, d23_r;
  logic [F:0] s01_r, t01_r, s23_r, t23_r, qi3_r [2];
  logic has23_r, bnd3_r;
  logic [CWW-1:0] cw3_r;
  logic lt10, pick3;

  // stage 4: final choice
  logic take23;
  logic [F:0] ws_r, wt_r;
  logic bnd4_r;
  logic [CWW-1:0] cw4_r;

  assign cw_in = side_i[7*E+SSC_CASE_BITS +: CWW];
  assign vw_i  = $signed(side_i[SSC_CASE_BITS+6*E +: E]);
  assign a_i   = $signed(side_i[SSC_CASE_BITS+5*E +: E]);
  assign uw_i  = $signed(side_i[SSC_CASE_BITS+4*E +: E]);
  assign b_i   = $signed(side_i[SSC_CASE_BITS+3*E +: E]);
  assign fl_in = side_i[SSC_CASE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  // build distances; all are kept as (dist^2 - w.w) scaled by 2^F
  always_comb begin
    d_nxt[0]  = fl1_r.s0_zero ? '0 : fl1_r.s0_full ? vv2vw1_r : pr1_r[0];
    cs_nxt[0] = '0;
    ct_nxt[0] = fl1_r.s0_zero ? '0 : fl1_r.s0_full ? ONE : {1'b0, q1_r[0]};
    d_nxt[1]  = fl1_r.s1_zero ? uu2uw1_r :
                fl1_r.s1_full ? e111_r : uu2uw1_r - pr1_r[1];
    cs_nxt[1] = ONE;
    ct_nxt[1] = fl1_r.s1_zero ? '0 : fl1_r.s1_full ? ONE : {1'b0, q1_r[1]};
    d_nxt[2]  = -pr1_r[2];
    cs_nxt[2] = {1'b0, q1_r[2]};
    ct_nxt[2] = '0;
    d_nxt[3]  = vv2vw1_r - pr1_r[3];
    cs_nxt[3] = {1'b0, q1_r[3]};
    ct_nxt[3] = ONE;
  end

  // earlier candidate wins a tie
  assign lt10   = d2_r[1] < d2_r[0];
  assign pick3  = fl2_r.t1_ok && (!fl2_r.t0_ok || (d2_r[3] < d2_r[2]));
  assign take23 = has23_r && (d23_r < d01_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pr1_r[0] <= $signed({1'b0, q_i[0]}) * vw_i;
      pr1_r[1] <= $signed({1'b0, q_i[1]}) * a_i;
      pr1_r[2] <= $signed({1'b0, q_i[2]}) * uw_i;
      pr1_r[3] <= $signed({1'b0, q_i[3]}) * b_i;
      vv2vw1_r <= R'($signed(side_i[SSC_CASE_BITS+2*E +: E])) <<< F;
      uu2uw1_r <= R'($signed(side_i[SSC_CASE_BITS+E +: E])) <<< F;
      e111_r   <= R'($signed(side_i[SSC_CASE_BITS +: E])) <<< F;
      q1_r     <= q_i;
      fl1_r    <= fl_in;
      cw1_r    <= cw_in;

      d2_r     <= d_nxt;
      cs2_r    <= cs_nxt;
      ct2_r    <= ct_nxt;
      qi2_r[0] <= {1'b0, q1_r[0]};
      qi2_r[1] <= {1'b0, q1_r[1]};
      fl2_r    <= fl1_r;
      cw2_r    <= cw1_r;

      d01_r   <= lt10 ? d2_r[1] : d2_r[0];
      s01_r   <= lt10 ? cs2_r[1] : cs2_r[0];
      t01_r   <= lt10 ? ct2_r[1] : ct2_r[0];
      d23_r   <= pick3 ? d2_r[3] : d2_r[2];
      s23_r   <= pick3 ? cs2_r[3] : cs2_r[2];
      t23_r   <= pick3 ? ct2_r[3] : ct2_r[2];
      has23_r <= fl2_r.t0_ok || fl2_r.t1_ok;
      bnd3_r  <= fl2_r.bnd;
      qi3_r   <= qi2_r;
      cw3_r   <= cw2_r;

      ws_r   <= !bnd3_r ? qi3_r[0] : take23 ? s23_r : s01_r;
      wt_r   <= !bnd3_r ? qi3_r[1] : take23 ? t23_r : t01_r;
      bnd4_r <= bnd3_r;
      cw4_r  <= cw3_r;
    end
  end

  assign vld_o = vld_r[3];
  assign ws_o  = ws_r;
  assign wt_o  = wt_r;
  assign bnd_o = bnd4_r;
  assign cw_o  = cw4_r;

endmodule

// File: sv/ssc_gap.sv
// ----------------------------------------------------------------------------
// ssc_gap
// Gap vector s*u - t*v - w with truncation toward zero, and the output
// register that holds each result word until it is taken.
// ----------------------------------------------------------------------------
module ssc_gap import ssc_pkg::*; #(
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [WEIGHT_FRAC_BITS:0]   ws_i,
  input  logic [WEIGHT_FRAC_BITS:0]   wt_i,
  input  logic                        bnd_i,
  input  logic [9*(COORD_BITS+1)-1:0] cw_i,
  output logic                        vld_o,
  output logic signed [17:0]          gap_o [3],
  output logic [16:0]                 ws_o,
  output logic [16:0]                 wt_o,
  output logic                        bnd_o
);

  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int D  = COORD_BITS + 1;
  localparam int NW = F + D + 3;

  logic signed [NW-1:0] pa_r [3], pb_r [3], num [3], g [3];
  logic signed [D-1:0] w1_r [3];
  logic [F+17:0] wsx, wtx;
  logic [F:0] ws1_r, wt1_r;
  logic bnd1_r, vld1_r, vld2_r;
  logic signed [17:0] gap_r [3];
  logic [16:0] ws2_r, wt2_r;
  logic bnd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  // sum, then truncate the Q1.F scaling toward zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = pa_r[k] - pb_r[k] - (NW'(w1_r[k]) <<< F);
      g[k]   = (num[k] >>> F) + NW'(num[k][NW-1] && (num[k][F-1:0] != '0));
    end
    wsx = (F+18)'(ws1_r);
    wtx = (F+18)'(wt1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa_r[k] <= $signed({1'b0, ws_i}) * $signed(cw_i[(8-k)*D +: D]);
        pb_r[k] <= $signed({1'b0, wt_i}) * $signed(cw_i[(5-k)*D +: D]);
        w1_r[k] <= $signed(cw_i[(2-k)*D +: D]);
        gap_r[k] <= g[k][17:0];
      end
      ws1_r  <= ws_i;
      wt1_r  <= wt_i;
      bnd1_r <= bnd_i;
      ws2_r  <= wsx[16:0];
      wt2_r  <= wtx[16:0];
      bnd2_r <= bnd1_r;
    end
  end

  assign vld_o = vld2_r;
  assign gap_o = gap_r;
  assign ws_o  = ws2_r;
  assign wt_o  = wt2_r;
  assign bnd_o = bnd2_r;

endmodule

// File: sv/segment_segment_closest_points_top.sv
// ----------------------------------------------------------------------------
// segment_segment_closest_points_top
// Closest points between two 3D segments, one segment pair per word.
//
//   channel  handshake             payload
//   in_      in_valid / in_stall    twelve endpoint coordinates, signed Q8.8
//   out_     out_valid / out_stall  gap x/y/z, both weights (Q1.16), boundary
//
// One word enters per cycle while a valid output is not stalled; each word
// runs through the front end, the two-bit-per-stage divider, picker and gap.
// Reset clears only the valid bits. A stalled valid output freezes the whole
// pipeline, and in_stall follows it in the same cycle.
// ----------------------------------------------------------------------------
module segment_segment_closest_points_top import ssc_pkg::*; #(
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_first_start_x,
  input  logic signed [COORD_BITS-1:0] in_first_start_y,
  input  logic signed [COORD_BITS-1:0] in_first_start_z,
  input  logic signed [COORD_BITS-1:0] in_first_end_x,
  input  logic signed [COORD_BITS-1:0] in_first_end_y,
  input  logic signed [COORD_BITS-1:0] in_first_end_z,
  input  logic signed [COORD_BITS-1:0] in_second_start_x,
  input  logic signed [COORD_BITS-1:0] in_second_start_y,
  input  logic signed [COORD_BITS-1:0] in_second_start_z,
  input  logic signed [COORD_BITS-1:0] in_second_end_x,
  input  logic signed [COORD_BITS-1:0] in_second_end_y,
  input  logic signed [COORD_BITS-1:0] in_second_end_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [17:0]           out_gap_x,
  output logic signed [17:0]           out_gap_y,
  output logic signed [17:0]           out_gap_z,
  output logic [16:0]                  out_weight_first,
  output logic [16:0]                  out_weight_second,
  output logic                         out_on_boundary
);

  localparam int D   = COORD_BITS + 1;
  localparam int Q   = 4 * COORD_BITS + 9;
  localparam int E   = 2 * COORD_BITS + 8;
  localparam int SBW = 9 * D + 7 * E + SSC_CASE_BITS;
  localparam int F   = WEIGHT_FRAC_BITS;

  logic en;
  logic signed [COORD_BITS-1:0] pt [12];
  logic fr_vld, dv_vld, pk_vld;
  logic [Q-1:0] num [4], den [4];
  logic [SBW-1:0] fr_side, dv_side;
  logic [F-1:0] q [4];
  logic [F:0] ws, wt;
  logic bnd;
  logic [9*D-1:0] cw;
  logic signed [17:0] gap [3];

  // advance everything unless a finished word is held back
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign pt = '{in_first_start_x, in_first_start_y, in_first_start_z,
                in_first_end_x, in_first_end_y, in_first_end_z,
                in_second_start_x, in_second_start_y, in_second_start_z,
                in_second_end_x, in_second_end_y, in_second_end_z};

  ssc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_valid), .pt_i(pt),
    .vld_o(fr_vld), .num_o(num), .den_o(den), .side_o(fr_side)
  );

  ssc_div #(.W(Q), .F(F), .SBW(SBW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(fr_vld), .num_i(num),
    .den_i(den), .side_i(fr_side), .vld_o(dv_vld), .q_o(q), .side_o(dv_side)
  );

  ssc_pick #(.COORD_BITS(COORD_BITS), .WEIGHT_FRAC_BITS(F)) u_pick (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(dv_vld), .q_i(q),
    .side_i(dv_side), .vld_o(pk_vld), .ws_o(ws), .wt_o(wt), .bnd_o(bnd),
    .cw_o(cw)
  );

  ssc_gap #(.COORD_BITS(COORD_BITS), .WEIGHT_FRAC_BITS(F)) u_gap (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(pk_vld), .ws_i(ws), .wt_i(wt),
    .bnd_i(bnd), .cw_i(cw), .vld_o(out_valid), .gap_o(gap),
    .ws_o(out_weight_first), .wt_o(out_weight_second), .bnd_o(out_on_boundary)
  );

  assign out_gap_x = gap[0];
  assign out_gap_y = gap[1];
  assign out_gap_z = gap[2];

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams segment pairs through the closest-point block under random input
// gaps and output stalls. A behavioral solver predicts the weights, the gap
// vector and the boundary flag of each pair, and every output word is checked
// in order against it.
// ----------------------------------------------------------------------------
module testbench;
  import ssc_pkg::*;

  typedef logic signed [15:0]  coord_t;
  typedef logic signed [127:0] big_t;

  typedef struct {
    coord_t p[12];
  } seg_pair_t;

  typedef struct packed {
    logic signed [17:0] gx;
    logic signed [17:0] gy;
    logic signed [17:0] gz;
    logic [16:0]        wf;
    logic [16:0]        ws;
    logic               bnd;
  } closest_t;

  localparam int  FRAC      = 16;
  localparam big_t ONE      = big_t'(1) <<< FRAC;
  localparam int  DOG_LIMIT = 4000;
  localparam int  N_RANDOM  = 850;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_c[12] = '{default: '0};
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic signed [17:0] out_gap_x, out_gap_y, out_gap_z;
  logic [16:0] out_weight_first, out_weight_second;
  logic        out_on_boundary;

  seg_pair_t pending_pairs[$];
  closest_t  expected_points[$];
  int        errors = 0;
  int        cycle_no = 0;
  int        dog = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_segment_closest_points_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_start_x(in_c[0]), .in_first_start_y(in_c[1]),
    .in_first_start_z(in_c[2]), .in_first_end_x(in_c[3]),
    .in_first_end_y(in_c[4]), .in_first_end_z(in_c[5]),
    .in_second_start_x(in_c[6]), .in_second_start_y(in_c[7]),
    .in_second_start_z(in_c[8]), .in_second_end_x(in_c[9]),
    .in_second_end_y(in_c[10]), .in_second_end_z(in_c[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_gap_x(out_gap_x), .out_gap_y(out_gap_y), .out_gap_z(out_gap_z),
    .out_weight_first(out_weight_first), .out_weight_second(out_weight_second),
    .out_on_boundary(out_on_boundary)
  );

  // floor(n*S/d) for 0 < n < d
  function automatic big_t weight_quot(big_t n, big_t d);
    return (n <<< FRAC) / d;
  endfunction

  // Solve the closest points of one segment pair
  function automatic closest_t solve_closest(seg_pair_t sp);
    big_t u[3], v[3], w[3];
    big_t uu, vv, uv, uw, vw, den, rhs1, rhs2;
    big_t d, nd, a, b, q, uu2uw, vv2vw;
    big_t ws, wt;
    longint num;
    logic   bnd;
    closest_t r;
    for (int k = 0; k < 3; k++) begin
      u[k] = big_t'(sp.p[3+k]) - big_t'(sp.p[k]);
      v[k] = big_t'(sp.p[9+k]) - big_t'(sp.p[6+k]);
      w[k] = big_t'(sp.p[6+k]) - big_t'(sp.p[k]);
    end
    uu = 0; vv = 0; uv = 0; uw = 0; vw = 0;
    for (int k = 0; k < 3; k++) begin
      uu += u[k] * u[k]; vv += v[k] * v[k]; uv += u[k] * v[k];
      uw += u[k] * w[k]; vw += v[k] * w[k];
    end
    den  = uu * vv - uv * uv;
    rhs1 = vv * uw - uv * vw;
    rhs2 = uv * uw - uu * vw;
    bnd = !(rhs1 > 0 && rhs1 < den && rhs2 > 0 && rhs2 < den);
    if (!bnd) begin
      ws = weight_quot(rhs1, den);
      wt = weight_quot(rhs2, den);
    end else begin
      uu2uw = uu - 2 * uw;
      vv2vw = vv + 2 * vw;
      // side s=0
      ws = 0;
      if (vw >= 0) begin
        d = 0; wt = 0;
      end else if (-vw >= vv) begin
        d = vv2vw * ONE; wt = ONE;
      end else begin
        wt = weight_quot(-vw, vv); d = wt * vw;
      end
      // side s=1
      a = uv - vw;
      b = uv + uw;
      if (a <= 0) begin
        nd = uu2uw * ONE;
        if (nd < d) begin d = nd; ws = ONE; wt = 0; end
      end else if (a >= vv) begin
        nd = (vv + 2 * (vw - b) + uu) * ONE;
        if (nd < d) begin d = nd; ws = ONE; wt = ONE; end
      end else begin
        q = weight_quot(a, vv);
        nd = uu2uw * ONE - q * a;
        if (nd < d) begin d = nd; ws = ONE; wt = q; end
      end
      // side t=0
      if (uw > 0 && uw < uu) begin
        q = weight_quot(uw, uu);
        nd = -(q * uw);
        if (nd < d) begin d = nd; ws = q; wt = 0; end
      end
      // side t=1
      if (b > 0 && b < uu) begin
        q = weight_quot(b, uu);
        nd = vv2vw * ONE - q * b;
        if (nd < d) begin d = nd; ws = q; wt = ONE; end
      end
    end
    num = longint'(ws) * longint'(u[0]) - longint'(wt) * longint'(v[0])
          - longint'(w[0]) * longint'(ONE);
    r.gx = 18'(num / longint'(ONE));
    num = longint'(ws) * longint'(u[1]) - longint'(wt) * longint'(v[1])
          - longint'(w[1]) * longint'(ONE);
    r.gy = 18'(num / longint'(ONE));
    num = longint'(ws) * longint'(u[2]) - longint'(wt) * longint'(v[2])
          - longint'(w[2]) * longint'(ONE);
    r.gz = 18'(num / longint'(ONE));
    r.wf = 17'(ws);
    r.ws = 17'(wt);
    r.bnd = bnd;
    return r;
  endfunction

  // Random pair: full range, small box, a collapsed segment or parallel segments
  function automatic seg_pair_t random_pair();
    seg_pair_t sp;
    int mode, span;
    coord_t base;
    mode = $urandom_range(0, 9);
    span = (mode < 6) ? 32'($urandom_range(16, 4000)) : 32'($urandom_range(1, 300));
    for (int k = 0; k < 12; k++) begin
      if (mode < 3) sp.p[k] = coord_t'($urandom);
      else sp.p[k] = coord_t'($signed($urandom_range(0, 2 * span)) - span);
    end
    // collapse a segment, or make them parallel
    if (mode == 8) begin
      for (int k = 0; k < 3; k++) sp.p[9+k] = sp.p[6+k];
    end else if (mode == 9) begin
      for (int k = 0; k < 3; k++) sp.p[9+k] = sp.p[6+k] + (sp.p[3+k] - sp.p[k]);
    end
    return sp;
  endfunction

  function automatic seg_pair_t make_pair(int a0, int a1, int a2, int b0, int b1, int b2,
                                          int c0, int c1, int c2, int d0, int d1, int d2);
    seg_pair_t sp;
    sp.p = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
             coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2), coord_t'(d0),
             coord_t'(d1), coord_t'(d2)};
    return sp;
  endfunction

  // Fill the queue: directed pairs, then random ones
  initial begin
    seg_pair_t sp;
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                                      32767, -32768, 32767, -32768, 32767, -32768));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768,
                                      -32768, -32768, -32768, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, 0, 0, 32767, 0, 0, 0, -32768, 256, 0, 32767, 256));
    pending_pairs.push_back(make_pair(-256, 0, 0, 256, 0, 0, 0, -256, 256, 0, 256, 256));
    pending_pairs.push_back(make_pair(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 256, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 256, 0, 0, 512, 0, 0, 768, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 256, 0, 0, 128, 0, 0, 384, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(5, 5, 5, 5, 5, 5, 100, 0, 0, -100, 300, 7));
    pending_pairs.push_back(make_pair(0, 0, 0, 512, 0, 0, 900, 100, 0, 900, 100, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 512, 0, 0, -300, 200, 50, 800, 200, 50));
    pending_pairs.push_back(make_pair(0, 0, 0, 512, 0, 0, 1000, -300, 40, 1000, 300, 40));
    pending_pairs.push_back(make_pair(0, 0, 0, 512, 0, 0, -700, -300, 40, -700, 300, 40));
    pending_pairs.push_back(make_pair(0, 0, 0, 512, 512, 0, 700, 0, 30, 0, 700, 30));
    pending_pairs.push_back(make_pair(-32768, 32767, 0, -32768, 32767, 0,
                                      32767, -32768, 0, 32767, -32768, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 256, 0, 0, 300, 10, 0, 300, 400, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 256, 0, 0, 100, 10, 0, 100, 400, 0));
    pending_pairs.push_back(make_pair(-1, -1, -1, 1, 1, 1, 1, -1, 1, -1, 1, -1));
    for (int i = 0; i < N_RANDOM; i++) begin
      sp = random_pair();
      pending_pairs.push_back(sp);
    end
  end

  // Reset, then wait for the pipeline to drain
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (pending_pairs.size() == 0 && !in_valid && expected_points.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  function automatic bit quiet_stretch();
    return cycle_no >= 400 && cycle_no < 800;
  endfunction

  // Drive input words; hold while stalled
  always @(posedge clk) begin
    seg_pair_t sp;
    cycle_no <= cycle_no + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        for (int k = 0; k < 12; k++) sp.p[k] = in_c[k];
        expected_points.push_back(solve_closest(sp));
      end
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() > 0 && (quiet_stretch() || $urandom_range(0, 99) >= 19)) begin
          sp = pending_pairs.pop_front();
          for (int k = 0; k < 12; k++) in_c[k] <= sp.p[k];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Check output words and drive stall
  always @(posedge clk) begin
    closest_t e;
    if (rst_n) begin
      out_stall <= !quiet_stretch() && ($urandom_range(0, 99) < 19);
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          e = expected_points.pop_front();
          if (out_gap_x !== e.gx) report_mismatch("gap_x", out_gap_x, e.gx);
          if (out_gap_y !== e.gy) report_mismatch("gap_y", out_gap_y, e.gy);
          if (out_gap_z !== e.gz) report_mismatch("gap_z", out_gap_z, e.gz);
          if (out_weight_first !== e.wf)
            report_mismatch("weight_first", out_weight_first, e.wf);
          if (out_weight_second !== e.ws)
            report_mismatch("weight_second", out_weight_second, e.ws);
          if (out_on_boundary !== e.bnd)
            report_mismatch("on_boundary", out_on_boundary, e.bnd);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dog <= 0;
    end else if (dog >= DOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      dog <= dog + 1;
    end
  end

endmodule

// File: sim.f
sv/ssc_pkg.sv
sv/ssc_front.sv
sv/ssc_div.sv
sv/ssc_pick.sv
sv/ssc_gap.sv
sv/segment_segment_closest_points_top.sv
dv/testbench.sv
